// File: rtl/wlgc_pkg.sv
// Shared types and constants for the water level gate controller.
package wlgc_pkg;

    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CFG_MAX_HEIGHT   = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_SONAR_OFFSET = 1'b1;

    localparam logic [15:0] MAX_HEIGHT_RST   = 16'd480;
    localparam logic [15:0] SONAR_OFFSET_RST = 16'd64;

    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_OPEN   = 2'd1;
    localparam logic [1:0] FUNC_CLOSE  = 2'd2;

    localparam logic [1:0] LVL_LOW  = 2'd0;
    localparam logic [1:0] LVL_MED  = 2'd1;
    localparam logic [1:0] LVL_HIGH = 2'd2;
    localparam logic [1:0] LVL_CRIT = 2'd3;

    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_OPEN  = 2'd1;
    localparam logic [1:0] DIR_CLOSE = 2'd2;

    localparam int InTdataW  = 24;
    localparam int OutTdataW = 32;

    // One accepted item as held in the input register.
    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] sonar_distance;
        logic        manual_mode;
        logic        button_level;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [1:0]  water_level;
        logic [16:0] clamp_height;
        logic [1:0]  gate_position;
        logic [1:0]  motor_direction;
        logic [1:0]  motor_steps;
        logic        buzzer_on;
    } result_t;

    // Current gate and buzzer state, visible to the top level.
    typedef struct packed {
        logic [1:0] gate_pos;
        logic       buzzer;
    } ctrl_state_t;

endpackage

// File: rtl/wlgc_level.sv
// Water height from a sonar distance and its four-way level classification.
module wlgc_level
    import wlgc_pkg::*;
(
    input  logic [15:0] max_height,
    input  logic [15:0] sonar_offset,
    input  logic [15:0] sonar_distance,
    output logic [16:0] clamp_height,
    output logic [1:0]  level
);

    logic [16:0] top;
    logic [18:0] h4;
    logic [18:0] h2;
    logic [18:0] maxh;
    logic [18:0] maxh3;

    assign top = {1'b0, max_height} + {1'b0, sonar_offset};
    assign clamp_height = (top > {1'b0, sonar_distance}) ?
                          (top - {1'b0, sonar_distance}) : 17'd0;

    // thresholds compared exactly: 4h, 2h against max and 3*max
    assign h4    = {clamp_height, 2'b00};
    assign h2    = {1'b0, clamp_height, 1'b0};
    assign maxh  = {3'b000, max_height};
    assign maxh3 = {2'b00, max_height, 1'b0} + maxh;

    always_comb begin
        if (h4 <= maxh) begin
            level = LVL_LOW;
        end else if (h2 <= maxh) begin
            level = LVL_MED;
        end else if (h4 <= maxh3) begin
            level = LVL_HIGH;
        end else begin
            level = LVL_CRIT;
        end
    end

endmodule

// File: rtl/wlgc_ctrl.sv
// Level history, gate position and buzzer state with per-item update.
module wlgc_ctrl
    import wlgc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  item_t       item,
    input  logic [16:0] clamp_height,
    input  logic [1:0]  level,
    output result_t     result,
    output ctrl_state_t state
);

    // only the two newest history entries are kept; the incoming level is the third
    logic [1:0] hist1_reg, hist2_reg;
    logic [1:0] hist1_next, hist2_next;
    logic [1:0] gate_reg, gate_next;
    logic       buzzer_reg, buzzer_next;
    logic [1:0] dir;
    logic [1:0] steps;
    logic       press_ok;

    assign press_ok = item.manual_mode & item.button_level;

    always_comb begin
        hist1_next  = hist1_reg;
        hist2_next  = hist2_reg;
        gate_next   = gate_reg;
        buzzer_next = buzzer_reg;
        dir         = DIR_NONE;
        steps       = 2'd0;
        case (item.func)
            FUNC_SAMPLE: begin
                hist1_next = hist2_reg;
                hist2_next = level;
                if ((hist1_reg == hist2_reg) && (hist2_reg == level)) begin
                    buzzer_next = (level == LVL_CRIT);
                    if (!item.manual_mode && (level != gate_reg)) begin
                        if (level < gate_reg) begin
                            dir   = DIR_CLOSE;
                            steps = gate_reg - level;
                        end else begin
                            dir   = DIR_OPEN;
                            steps = level - gate_reg;
                        end
                        gate_next = level;
                    end
                end
            end
            FUNC_OPEN: begin
                if (press_ok && (gate_reg != LVL_CRIT)) begin
                    gate_next = gate_reg + 2'd1;
                    dir       = DIR_OPEN;
                    steps     = 2'd1;
                end
            end
            FUNC_CLOSE: begin
                if (press_ok && (gate_reg != LVL_LOW)) begin
                    gate_next = gate_reg - 2'd1;
                    dir       = DIR_CLOSE;
                    steps     = 2'd1;
                end
            end
            default: begin
                // unused code: no state change, no move
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist1_reg  <= LVL_LOW;
            hist2_reg  <= LVL_LOW;
            gate_reg   <= LVL_LOW;
            buzzer_reg <= 1'b0;
        end else if (step_en) begin
            hist1_reg  <= hist1_next;
            hist2_reg  <= hist2_next;
            gate_reg   <= gate_next;
            buzzer_reg <= buzzer_next;
        end
    end

    assign result.water_level     = hist2_next;
    assign result.clamp_height    = (item.func == FUNC_SAMPLE) ? clamp_height : 17'd0;
    assign result.gate_position   = gate_next;
    assign result.motor_direction = dir;
    assign result.motor_steps     = steps;
    assign result.buzzer_on       = buzzer_next;

    assign state.gate_pos = gate_reg;
    assign state.buzzer   = buzzer_reg;

endmodule

// File: rtl/water_level_gate_controller_core.sv
// Top level of the water level gate controller: channels, registers, assertions.
//
// Usage:
//   Input stream (s_axis): one transfer per item. tuser carries func (0 sonar
//   sample, 1 manual open press, 2 manual close press); tdata carries the
//   sonar distance and the manual mode / button levels.
//   Output stream (m_axis): exactly one result transfer per input transfer,
//   in order: level, clamped height, gate position, motor direction/steps,
//   buzzer state.
//   Config port: cfg_we writes cfg_wdata into register cfg_addr
//   (0 max_height, 1 sonar_offset); write only while the block is idle.
// Data path: the input register, then evaluation into the result register.
// Throughput: one item per cycle while m_tready stays high; the only loop is the
//   update of history, gate and buzzer state, which sits in the evaluation stage.
// Reset (aresetn low, synchronous): both stages empty, history all low, gate
//   low, buzzer off, registers back to 480 and 64.
// Stall: when m_tready is low the result register holds; the input register
//   still takes one more item, then s_tready drops until the result moves.
module water_level_gate_controller_core
    import wlgc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // config write port
    input  logic                 cfg_we,
    input  logic [CfgIdxW-1:0]   cfg_addr,
    input  logic [CfgDataW-1:0]  cfg_wdata,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [InTdataW-1:0]  s_tdata,   // [15:0] sonar_distance, [16] manual_mode,
                                            // [17] button_level, [23:18] zero
    input  logic [1:0]           s_tuser,   // [1:0] func
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OutTdataW-1:0] m_tdata    // [1:0] water_level, [18:2] clamp_height,
                                            // [20:19] gate_position,
                                            // [22:21] motor_direction,
                                            // [24:23] motor_steps, [25] buzzer_on,
                                            // [31:26] zero
);

    logic [15:0] max_height_reg;
    logic [15:0] sonar_offset_reg;

    logic        in_vld_reg;
    item_t       in_item_reg;
    logic        out_vld_reg;
    result_t     out_res_reg;

    logic        out_adv;    // result register can load this cycle
    logic        step_en;    // evaluation stage fires
    logic        in_xfer;

    logic [16:0] clamp_height;
    logic [1:0]  level;
    result_t     result;
    ctrl_state_t state;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_height_reg   <= MAX_HEIGHT_RST;
            sonar_offset_reg <= SONAR_OFFSET_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_MAX_HEIGHT:   max_height_reg   <= cfg_wdata;
                CFG_SONAR_OFFSET: sonar_offset_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // handshake: the input stage drains whenever the result register frees up
    assign out_adv  = !out_vld_reg || m_tready;
    assign step_en  = in_vld_reg && out_adv;
    assign s_tready = !in_vld_reg || out_adv;
    assign in_xfer  = s_tvalid && s_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_item_reg.func           <= s_tuser;
            in_item_reg.sonar_distance <= s_tdata[15:0];
            in_item_reg.manual_mode    <= s_tdata[16];
            in_item_reg.button_level   <= s_tdata[17];
        end
    end

    wlgc_level u_level (
        .max_height     (max_height_reg),
        .sonar_offset   (sonar_offset_reg),
        .sonar_distance (in_item_reg.sonar_distance),
        .clamp_height   (clamp_height),
        .level          (level)
    );

    wlgc_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .item         (in_item_reg),
        .clamp_height (clamp_height),
        .level        (level),
        .result       (result),
        .state        (state)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_adv) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0,
                       out_res_reg.buzzer_on,
                       out_res_reg.motor_steps,
                       out_res_reg.motor_direction,
                       out_res_reg.gate_position,
                       out_res_reg.clamp_height,
                       out_res_reg.water_level};

    // a move always comes with a step count, and no step count without a move
    a_dir_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[22:21] == DIR_NONE) == (m_tdata[24:23] == 2'd0)))
        else $error("motor direction and step count disagree");

    // a freshly loaded result reports the gate and buzzer state it left behind
    a_gate_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> (m_tdata[20:19] == state.gate_pos) && (m_tdata[25] == state.buzzer))
        else $error("result gate/buzzer differs from controller state");

    // the input stage never holds an item while the result stage could take it idle
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !out_vld_reg) |=> out_vld_reg)
        else $error("evaluation stage failed to advance");

endmodule
